### src/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg: shared constants, types and helpers of the corner test
// Ring geometry, field widths, register indexes and the structs passed
// between the lane, run and merge logic.
// ----------------------------------------------------------------------------
`default_nettype none

package fct_pkg;

    // ring geometry
    localparam int RADIUS_DEF     = 3;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int RING_LEN       = 16;
    localparam int DIA_LEN        = 4;
    localparam int DIA_STRIDE     = RING_LEN / DIA_LEN;
    localparam int LANES_PER_WORD = 8;

    // field widths
    localparam int FIELD_PIX_W = 8;
    localparam int WORD_W      = FIELD_PIX_W * LANES_PER_WORD;
    localparam int THR_W       = 8;
    localparam int SUM_W       = THR_W + 1;
    localparam int DCNT_W      = 3;
    localparam int CCNT_W      = 5;
    localparam int RUN_W       = $clog2(RING_LEN + 1);
    localparam int DRUN_W      = $clog2(DIA_LEN + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIAMOND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCLE    = 2'd2;

    // register reset values
    localparam logic [THR_W-1:0]  THR_RESET  = 8'd20;
    localparam logic [DCNT_W-1:0] DCNT_RESET = 3'd3;
    localparam logic [CCNT_W-1:0] CCNT_RESET = 5'd12;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [DCNT_W-1:0] diamond_count;
        logic [CCNT_W-1:0] circle_count;
    } t_cfg;

    // per-sample comparison flags
    typedef struct packed {
        logic bgt;
        logic bge;
        logic dgt;
        logic dge;
    } t_lane_flags;

    // window-existence thermometers of both directions
    typedef struct packed {
        logic [RING_LEN-2:0] ring_b_ex;
        logic                ring_b_all;
        logic [RING_LEN-2:0] ring_d_ex;
        logic                ring_d_all;
        logic [DIA_LEN-2:0]  dia_b_ex;
        logic                dia_b_all;
        logic [DIA_LEN-2:0]  dia_d_ex;
        logic                dia_d_all;
    } t_runs;

    typedef struct packed {
        logic             is_corner;
        logic             diamond_pass;
        logic [RUN_W-1:0] bright_run;
        logic [RUN_W-1:0] dark_run;
    } t_result;

    // largest power of two strictly below k (k >= 2)
    function automatic int low_pow2(input int k);
        int p;
        p = 1;
        while (p * 2 < k) p = p * 2;
        return p;
    endfunction

endpackage

`default_nettype wire

### src/fct_if.sv
// ----------------------------------------------------------------------------
// fct_if: valid/ready channels of the corner test
// One interface for candidate pixel items and one for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface fct_in_if import fct_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FIELD_PIX_W-1:0] center_pixel;
    logic [WORD_W-1:0]      ring_pixels_low;
    logic [WORD_W-1:0]      ring_pixels_high;

    modport source (output valid, center_pixel, ring_pixels_low, ring_pixels_high,
                    input ready);
    modport sink   (input valid, center_pixel, ring_pixels_low, ring_pixels_high,
                    output ready);
endinterface

interface fct_out_if import fct_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             is_corner;
    logic             diamond_pass;
    logic [RUN_W-1:0] bright_run;
    logic [RUN_W-1:0] dark_run;

    modport source (output valid, is_corner, diamond_pass, bright_run, dark_run,
                    input ready);
    modport sink   (input valid, is_corner, diamond_pass, bright_run, dark_run,
                    output ready);
endinterface

`default_nettype wire

### src/fct_lane.sv
// ----------------------------------------------------------------------------
// fct_lane: threshold compare of one ring sample
// Flags whether the sample is brighter or darker than the center by more
// than, or by at least, the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_lane import fct_pkg::*; #(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  wire logic [PIXEL_BITS-1:0] i_px,
    input  wire logic [PIXEL_BITS-1:0] i_center,
    input  wire logic [THR_W-1:0]      i_threshold,
    output t_lane_flags                o_flags
);

    logic [SUM_W-1:0] px_ext;
    logic [SUM_W-1:0] c_ext;
    logic [SUM_W-1:0] c_plus_t;
    logic [SUM_W-1:0] px_plus_t;

    // offset each side by the threshold, compare unsigned
    always_comb begin
        px_ext    = SUM_W'(i_px);
        c_ext     = SUM_W'(i_center);
        c_plus_t  = c_ext + SUM_W'(i_threshold);
        px_plus_t = px_ext + SUM_W'(i_threshold);
        o_flags.bgt = px_ext > c_plus_t;
        o_flags.bge = px_ext >= c_plus_t;
        o_flags.dgt = c_ext > px_plus_t;
        o_flags.dge = c_ext >= px_plus_t;
    end

endmodule

`default_nettype wire

### src/fct_run.sv
// ----------------------------------------------------------------------------
// fct_run: circular window search over one flag vector
// Bit k-1 of o_exists is set when some circular window of k samples is all
// above threshold; windows are built by doubling, so depth grows as log LEN.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_run import fct_pkg::*; #(
    parameter int LEN = RING_LEN
) (
    input  wire logic [LEN-1:0] i_gt,
    input  wire logic [LEN-1:0] i_ge,
    output logic      [LEN-2:0] o_exists,
    output logic                o_all_ge
);

    logic [LEN-1:0] w [1:LEN-1];

    // w[k][i]: samples i .. i+k-1 (mod LEN) all above threshold
    always_comb begin
        w[1] = i_gt;
        for (int k = 2; k < LEN; k++) begin
            for (int i = 0; i < LEN; i++) begin
                w[k][i] = w[low_pow2(k)][i] & w[k - low_pow2(k)][(i + low_pow2(k)) % LEN];
            end
        end
        for (int k = 1; k < LEN; k++) begin
            o_exists[k-1] = |w[k];
        end
        o_all_ge = &i_ge;
    end

endmodule

`default_nettype wire

### src/fct_merge.sv
// ----------------------------------------------------------------------------
// fct_merge: run lengths and pass decisions
// Turns the window thermometers into run lengths and checks them against
// the diamond and circle counts.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_merge import fct_pkg::*; (
    input  wire t_runs i_runs,
    input  wire t_cfg  i_cfg,
    output t_result    o_result
);

    logic [RUN_W-1:0]  b_run;
    logic [RUN_W-1:0]  d_run;
    logic [DRUN_W-1:0] bd_run;
    logic [DRUN_W-1:0] dd_run;
    logic              dia;
    logic              ring;

    // count windows; a set that is all at least threshold is a full run
    always_comb begin
        b_run  = i_runs.ring_b_all ? RUN_W'(RING_LEN)
                                   : RUN_W'($countones(i_runs.ring_b_ex));
        d_run  = i_runs.ring_d_all ? RUN_W'(RING_LEN)
                                   : RUN_W'($countones(i_runs.ring_d_ex));
        bd_run = i_runs.dia_b_all ? DRUN_W'(DIA_LEN)
                                  : DRUN_W'($countones(i_runs.dia_b_ex));
        dd_run = i_runs.dia_d_all ? DRUN_W'(DIA_LEN)
                                  : DRUN_W'($countones(i_runs.dia_d_ex));

        dia  = (DCNT_W'(bd_run) >= i_cfg.diamond_count) ||
               (DCNT_W'(dd_run) >= i_cfg.diamond_count);
        ring = (CCNT_W'(b_run) >= i_cfg.circle_count) ||
               (CCNT_W'(d_run) >= i_cfg.circle_count);

        o_result.is_corner    = dia && ring;
        o_result.diamond_pass = dia;
        o_result.bright_run   = b_run;
        o_result.dark_run     = d_run;
    end

endmodule

`default_nettype wire

### src/fast_corner_test_top.sv
// ----------------------------------------------------------------------------
// fast_corner_test_top: radius-3 ring corner test, one candidate per cycle while o_res.ready is high
//
// i_pix carries one candidate item: center pixel and the 16 ring samples
// packed into two 64-bit words. o_res returns one result item per candidate:
// corner flag, diamond pre-test flag and the bright and dark run lengths.
// Both channels move an item when valid and ready are high at a clock edge.
// Sixteen compare lanes flag every ring sample in the first stage, window
// searches over the flags run in the second, and the merge stage fills the
// output register in the third: an accepted item is registered in stage 1,
// then in stage 2, then in the output register, where it raises o_res.valid.
// Throughput is one item per cycle while o_res.ready stays high, set by the
// three-stage pipeline; each stage moves on when the stage after it is empty or moving.
// When the receiver stalls, results back up stage by stage; i_pix.ready
// drops only once all three stages hold items.
// The write port sets threshold, diamond count and circle count; write it
// only while the pipeline is empty. Indexes past the last register are
// ignored.
// Synchronous reset empties the pipeline and loads threshold 20, diamond
// count 3 and circle count 12.
// ----------------------------------------------------------------------------
`default_nettype none

module fast_corner_test_top import fct_pkg::*; #(
    parameter int RADIUS     = RADIUS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    fct_in_if.sink                     i_pix,
    fct_out_if.source                  o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RING_SAMPLES = RADIUS * 4 + DIA_LEN;

    t_cfg                r_cfg;
    logic                r_s1_valid;
    logic                r_s2_valid;
    logic                r_out_valid;
    logic [RING_LEN-1:0] r_bgt, r_bge, r_dgt, r_dge;
    t_runs               r_runs;
    t_result             r_result;

    logic                en1, en2, en3;
    t_lane_flags         lane_flags [RING_SAMPLES];
    logic [RING_LEN-1:0] n_bgt, n_bge, n_dgt, n_dge;
    logic [DIA_LEN-1:0]  dia_bgt, dia_bge, dia_dgt, dia_dge;
    t_runs               n_runs;
    t_result             n_result;

    // stage enables: advance when the next stage is empty or advancing
    assign en3         = !r_out_valid || o_res.ready;
    assign en2         = !r_s2_valid || en3;
    assign en1         = !r_s1_valid || en2;
    assign i_pix.ready = en1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= THR_RESET;
            r_cfg.diamond_count <= DCNT_RESET;
            r_cfg.circle_count  <= CCNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD: r_cfg.threshold     <= THR_W'(i_cfg_data);
                REG_DIAMOND:   r_cfg.diamond_count <= DCNT_W'(i_cfg_data);
                REG_CIRCLE:    r_cfg.circle_count  <= CCNT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // compare lanes, one per ring sample
    for (genvar g = 0; g < RING_SAMPLES; g++) begin : g_lane
        logic [WORD_W-1:0] word;
        assign word = (g < LANES_PER_WORD) ? i_pix.ring_pixels_low : i_pix.ring_pixels_high;
        fct_lane #(.PIXEL_BITS(PIXEL_BITS)) u_lane (
            .i_px        (word[(g % LANES_PER_WORD) * FIELD_PIX_W +: PIXEL_BITS]),
            .i_center    (i_pix.center_pixel[PIXEL_BITS-1:0]),
            .i_threshold (r_cfg.threshold),
            .o_flags     (lane_flags[g])
        );
        assign n_bgt[g] = lane_flags[g].bgt;
        assign n_bge[g] = lane_flags[g].bge;
        assign n_dgt[g] = lane_flags[g].dgt;
        assign n_dge[g] = lane_flags[g].dge;
    end

    // stage 1: hold lane flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_bgt <= n_bgt;
            r_bge <= n_bge;
            r_dgt <= n_dgt;
            r_dge <= n_dge;
        end
    end

    // pick the diamond samples
    always_comb begin
        for (int i = 0; i < DIA_LEN; i++) begin
            dia_bgt[i] = r_bgt[i * DIA_STRIDE];
            dia_bge[i] = r_bge[i * DIA_STRIDE];
            dia_dgt[i] = r_dgt[i * DIA_STRIDE];
            dia_dge[i] = r_dge[i * DIA_STRIDE];
        end
    end

    // window searches, both directions, ring and diamond
    fct_run #(.LEN(RING_LEN)) u_run_rb (
        .i_gt (r_bgt), .i_ge (r_bge),
        .o_exists (n_runs.ring_b_ex), .o_all_ge (n_runs.ring_b_all)
    );
    fct_run #(.LEN(RING_LEN)) u_run_rd (
        .i_gt (r_dgt), .i_ge (r_dge),
        .o_exists (n_runs.ring_d_ex), .o_all_ge (n_runs.ring_d_all)
    );
    fct_run #(.LEN(DIA_LEN)) u_run_db (
        .i_gt (dia_bgt), .i_ge (dia_bge),
        .o_exists (n_runs.dia_b_ex), .o_all_ge (n_runs.dia_b_all)
    );
    fct_run #(.LEN(DIA_LEN)) u_run_dd (
        .i_gt (dia_dgt), .i_ge (dia_dge),
        .o_exists (n_runs.dia_d_ex), .o_all_ge (n_runs.dia_d_all)
    );

    // stage 2: hold window thermometers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_runs <= n_runs;
        end
    end

    // merge run lengths and decide
    fct_merge u_merge (
        .i_runs   (r_runs),
        .i_cfg    (r_cfg),
        .o_result (n_result)
    );

    // stage 3: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_result <= n_result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.is_corner    = r_result.is_corner;
    assign o_res.diamond_pass = r_result.diamond_pass;
    assign o_res.bright_run   = r_result.bright_run;
    assign o_res.dark_run     = r_result.dark_run;

endmodule

`default_nettype wire
